// ===== src/lzbp_pkg.sv =====
// ----------------------------------------------------------------------------
// LZSS byte/pixel decoder package
// Window sizing, token classes, status codes and the control bundles shared
// by the controller and the datapath.
// ----------------------------------------------------------------------------
package lzbp_pkg;

    localparam int WINDOW_BYTES = 16384;
    localparam int ADDR_W       = $clog2(WINDOW_BYTES);
    localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
    localparam int DIST_W       = 12;
    localparam int BACK_W       = DIST_W + 2;
    localparam int CMP_W        = (FILL_W > BACK_W) ? FILL_W : BACK_W;
    localparam int SUM_W        = ((ADDR_W > BACK_W) ? ADDR_W : BACK_W) + 1;
    localparam int CNT_W        = 7;

    localparam logic [ADDR_W-1:0] WP_LAST   = ADDR_W'(WINDOW_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_BYTES);
    localparam logic [SUM_W-1:0]  WIN_SUM   = SUM_W'(WINDOW_BYTES);

    localparam logic [3:0] FLAG_GROUP = 4'd8;

    // what the current input byte does to the token parser
    typedef enum logic [2:0] {
        K_FLAG = 3'd0,
        K_HOLD = 3'd1,
        K_LIT  = 3'd2,
        K_COPY = 3'd3,
        K_BAD  = 3'd4
    } tok_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_BAD_DIST = 2'd2
    } status_code_t;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic decode;
        logic rd;
        logic emit;
        logic tail;
        logic clear;
    } lzbp_cmd_t;

    typedef struct packed {
        logic      in_valid;
        tok_kind_t kind;
        logic      last;
        logic      final_byte;
        logic      out_free;
        logic      is_copy;
    } lzbp_sts_t;

endpackage

// ===== src/lzbp_if.sv =====
// ----------------------------------------------------------------------------
// LZSS decoder stream interfaces
// Valid/ready channels for compressed input bytes and decoded results.
// ----------------------------------------------------------------------------
interface lzbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, in_byte, last_byte, input ready);
    modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface lzbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
    logic [1:0] status;

    modport source (output valid, out_byte, byte_valid, run_last, stream_end, status,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, run_last, stream_end, status,
                    output ready);
endinterface

// ===== src/lzbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// LZSS decoder controller
// Sequences accept, token decode, history reads and result emission.
// ----------------------------------------------------------------------------
module lzbp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  lzbp_pkg::lzbp_sts_t sts,
    output lzbp_pkg::lzbp_cmd_t cmd
);
    import lzbp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_EMIT   = 5'b01000,
        S_TAIL   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                unique case (sts.kind) inside
                    K_FLAG, K_HOLD: state_next = sts.last ? S_TAIL : S_IDLE;
                    K_LIT:          state_next = S_EMIT;
                    K_COPY:         state_next = S_READ;
                    default:        state_next = S_TAIL;
                endcase
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.final_byte)
                    begin
                        cmd.clear  = sts.last;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = sts.is_copy ? S_READ : S_EMIT;
                    end
                end
            end
            S_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.tail   = 1'b1;
                    cmd.clear  = sts.last;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lzbp_datapath.sv =====
// ----------------------------------------------------------------------------
// LZSS decoder datapath
// Token parser state, history window memory, copy address arithmetic and the
// result output register.
// ----------------------------------------------------------------------------
module lzbp_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic                cfg_wdata,
    input  lzbp_pkg::lzbp_cmd_t cmd,
    output lzbp_pkg::lzbp_sts_t sts,
    lzbp_in_if.sink             in_ch,
    lzbp_out_if.source          out_ch
);
    import lzbp_pkg::*;

    logic                pixel_mode_reg;
    logic [7:0]          in_byte_reg;
    logic                last_reg;
    logic [7:0]          flag_bits_reg;
    logic [3:0]          flags_left_reg;
    logic [1:0]          token_phase_reg;
    logic [15:0]         held_reg;
    logic [ADDR_W-1:0]   write_pos_reg;
    logic [FILL_W-1:0]   filled_reg;
    logic [BACK_W-1:0]   back_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                is_copy_reg;
    status_code_t        status_reg;
    logic [7:0]          rdata_reg;

    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                byte_valid_reg;
    logic                run_last_reg;
    logic                stream_end_reg;
    status_code_t        out_status_reg;

    logic [7:0]          hist_mem [WINDOW_BYTES];

    // decode of the latched byte
    logic                lit;
    logic [1:0]          ph;
    logic [1:0]          need;
    logic                complete;
    logic [3:0]          len;
    logic [DIST_W-1:0]   dist_fld;
    logic [BACK_W-1:0]   back;
    logic                bad;
    tok_kind_t           kind;
    logic [CNT_W-1:0]    copy_count;
    logic [CNT_W-1:0]    lit_count;
    logic [SUM_W-1:0]    wp_ext;
    logic [SUM_W-1:0]    back_ext;
    logic [SUM_W-1:0]    src_ext;
    logic [ADDR_W-1:0]   rd_addr;
    logic [7:0]          lit_byte;
    logic [7:0]          emit_byte;
    logic                final_byte;
    logic                out_free;

    assign lit      = flag_bits_reg[0];
    assign ph       = token_phase_reg + 2'd1;
    assign need     = lit ? (pixel_mode_reg ? 2'd3 : 2'd1) : 2'd2;
    assign complete = (ph >= need);
    assign len      = held_reg[3:0];
    assign dist_fld = {in_byte_reg, held_reg[7:4]};
    assign back     = pixel_mode_reg ? {dist_fld, 2'b00} : {2'b00, dist_fld};
    assign bad      = (dist_fld == '0) || (CMP_W'(back) > CMP_W'(filled_reg));

    assign copy_count = pixel_mode_reg ? {({1'b0, len} + 5'd1), 2'b00}
                                       : ({3'b000, len} + 7'd2);
    assign lit_count  = pixel_mode_reg ? 7'd4 : 7'd1;

    always_comb
    begin
        if (flags_left_reg == '0)
        begin
            kind = K_FLAG;
        end
        else if (!complete)
        begin
            kind = K_HOLD;
        end
        else if (lit)
        begin
            kind = K_LIT;
        end
        else if (bad)
        begin
            kind = K_BAD;
        end
        else
        begin
            kind = K_COPY;
        end
    end

    // source = write_pos - back, modulo the window
    assign wp_ext   = SUM_W'(write_pos_reg);
    assign back_ext = SUM_W'(back_reg);
    assign src_ext  = (wp_ext >= back_ext) ? (wp_ext - back_ext)
                                           : (wp_ext + WIN_SUM - back_ext);
    assign rd_addr  = src_ext[ADDR_W-1:0];

    // pixel literal goes out as held lo, held hi, current byte, zero pad
    always_comb
    begin
        case (count_reg)
            7'd4:    lit_byte = held_reg[7:0];
            7'd3:    lit_byte = held_reg[15:8];
            7'd2:    lit_byte = in_byte_reg;
            default: lit_byte = pixel_mode_reg ? 8'h00 : in_byte_reg;
        endcase
    end

    assign emit_byte  = is_copy_reg ? rdata_reg : lit_byte;
    assign final_byte = (count_reg == 7'd1);
    assign out_free   = !out_valid_reg || out_ch.ready;

    assign sts.in_valid   = in_ch.valid;
    assign sts.kind       = kind;
    assign sts.last       = last_reg;
    assign sts.final_byte = final_byte;
    assign sts.out_free   = out_free;
    assign sts.is_copy    = is_copy_reg;

    assign in_ch.ready = cmd.in_ready;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.byte_valid = byte_valid_reg;
    assign out_ch.run_last   = run_last_reg;
    assign out_ch.stream_end = stream_end_reg;
    assign out_ch.status     = out_status_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg  <= 1'b0;
            flag_bits_reg   <= '0;
            flags_left_reg  <= '0;
            token_phase_reg <= '0;
            write_pos_reg   <= '0;
            filled_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                pixel_mode_reg <= cfg_wdata;
            end

            if (cmd.decode)
            begin
                if (kind == K_FLAG)
                begin
                    flag_bits_reg  <= in_byte_reg;
                    flags_left_reg <= FLAG_GROUP;
                end
                else if (complete)
                begin
                    token_phase_reg <= '0;
                    flag_bits_reg   <= {1'b0, flag_bits_reg[7:1]};
                    flags_left_reg  <= flags_left_reg - 4'd1;
                end
                else
                begin
                    token_phase_reg <= ph;
                end
            end

            if (cmd.emit)
            begin
                write_pos_reg <= (write_pos_reg == WP_LAST) ? '0
                                                            : write_pos_reg + 1'b1;
                if (filled_reg != FILL_FULL)
                begin
                    filled_reg <= filled_reg + 1'b1;
                end
            end

            // end of stream: fresh window and parser
            if (cmd.clear)
            begin
                flag_bits_reg   <= '0;
                flags_left_reg  <= '0;
                token_phase_reg <= '0;
                write_pos_reg   <= '0;
                filled_reg      <= '0;
            end

            if (cmd.emit || cmd.tail)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_byte_reg <= in_ch.in_byte;
            last_reg    <= in_ch.last_byte;
        end

        if (cmd.decode)
        begin
            is_copy_reg <= !lit;
            back_reg    <= back;
            count_reg   <= lit ? lit_count : copy_count;
            if (kind == K_BAD)
            begin
                status_reg <= ST_BAD_DIST;
            end
            else if (kind == K_HOLD && last_reg)
            begin
                status_reg <= ST_TRUNC;
            end
            else
            begin
                status_reg <= ST_OK;
            end
            if (kind == K_HOLD)
            begin
                if (ph == 2'd1)
                begin
                    held_reg <= {8'h00, in_byte_reg};
                end
                else
                begin
                    held_reg[15:8] <= in_byte_reg;
                end
            end
        end

        if (cmd.emit)
        begin
            count_reg      <= count_reg - 7'd1;
            out_byte_reg   <= emit_byte;
            byte_valid_reg <= 1'b1;
            run_last_reg   <= final_byte;
            stream_end_reg <= final_byte && last_reg;
            out_status_reg <= ST_OK;
        end
        else if (cmd.tail)
        begin
            out_byte_reg   <= 8'h00;
            byte_valid_reg <= 1'b0;
            run_last_reg   <= 1'b1;
            stream_end_reg <= last_reg;
            out_status_reg <= status_reg;
        end
    end

    // history window
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hist_mem[write_pos_reg] <= emit_byte;
        end
        if (cmd.rd)
        begin
            rdata_reg <= hist_mem[rd_addr];
        end
    end

endmodule

// ===== src/lzss_byte_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// LZSS byte/pixel decoder
// Streaming LZSS decompressor, one compressed byte per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one compressed byte per transaction, last_byte marks the
//   final byte of a stream. out_ch returns decoded bytes one per transaction;
//   run_last marks the last result of an input byte, stream_end the last
//   result of a stream, status flags truncated tokens and bad distances.
//   cfg_wen/cfg_wdata write pixel_mode; the user must do so only while the
//   decoder is idle, as the block itself does not enforce it.
// Sequencing:
//   One input byte at a time: each byte is accepted, then decoded. A literal
//   then emits its 1 or 4 output bytes; a copy reads and emits each output
//   byte in turn (up to 64): a registered read of the single-port history
//   RAM, then its write. An error or end-of-stream status adds one result.
// Reset / stall:
//   Reset clears the parser, the window pointers and pixel_mode; the history
//   RAM is not cleared. A stalled out_ch holds the result register and the
//   decoder waits; a new byte is accepted once the last result is loaded.
// ----------------------------------------------------------------------------
module lzss_byte_pixel_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    lzbp_in_if.sink     in_ch,
    lzbp_out_if.source  out_ch
);
    import lzbp_pkg::*;

    lzbp_cmd_t cmd;
    lzbp_sts_t sts;

    lzbp_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    lzbp_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

// ===== dv/lzbp_checker.sv =====
// ----------------------------------------------------------------------------
// LZSS byte/pixel decoder checker
// Watches the config port and both stream channels, decodes every accepted
// compressed byte into the results the decoder must return, and compares each
// output transaction in order against them.
// ----------------------------------------------------------------------------
module lzbp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    lzbp_in_if          in_ch,
    lzbp_out_if         out_ch,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lzbp_pkg::*;

    typedef struct packed {
        logic [7:0]   data;
        logic         byte_valid;
        logic         run_last;
        logic         stream_end;
        status_code_t status;
    } decoded_t;

    decoded_t pending_results[$];
    decoded_t step_results[$];

    logic [7:0]        window_mem [WINDOW_BYTES];
    logic [ADDR_W-1:0] wr_ptr;
    int                fill_cnt;
    logic [7:0]        flag_reg;
    int                flags_remaining;
    int                tok_phase;
    logic [15:0]       held_word;
    logic              mode_pixel;

    function automatic void restart_stream();
        wr_ptr          = '0;
        fill_cnt        = 0;
        flag_reg        = '0;
        flags_remaining = 0;
        tok_phase       = 0;
        held_word       = '0;
    endfunction

    function automatic void append_result(logic [7:0] v, logic vld, status_code_t st);
        decoded_t r;
        r.data       = v;
        r.byte_valid = vld;
        r.run_last   = 1'b0;
        r.stream_end = 1'b0;
        r.status     = st;
        step_results.push_back(r);
    endfunction

    function automatic void emit_decoded(logic [7:0] v);
        window_mem[wr_ptr] = v;
        wr_ptr = (wr_ptr == WP_LAST) ? '0 : wr_ptr + 1'b1;
        if (fill_cnt < WINDOW_BYTES)
            fill_cnt++;
        append_result(v, 1'b1, ST_OK);
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic is_last);
        status_code_t st;
        logic         is_lit;
        int           ph;
        int           need;
        logic [15:0]  held;
        logic [15:0]  word;
        int           len;
        int           dist_fld;
        int           back;
        int           count;
        int           src;
        st = ST_OK;
        step_results.delete();
        if (flags_remaining == 0) begin
            flag_reg        = b;
            flags_remaining = 8;
        end
        else begin
            is_lit = flag_reg[0];
            ph     = tok_phase + 1;
            need   = is_lit ? (mode_pixel ? 3 : 1) : 2;
            if (ph >= need) begin
                held      = held_word;
                tok_phase = 0;
                held_word = '0;
                flag_reg  = flag_reg >> 1;
                flags_remaining--;
                if (is_lit) begin
                    if (mode_pixel) begin
                        emit_decoded(held[7:0]);
                        emit_decoded(held[15:8]);
                        emit_decoded(b);
                        emit_decoded(8'h00);
                    end
                    else begin
                        emit_decoded(b);
                    end
                end
                else begin
                    word     = {b, held[7:0]};
                    len      = int'(word[3:0]);
                    dist_fld = int'(word[15:4]);
                    back     = mode_pixel ? dist_fld * 4 : dist_fld;
                    count    = mode_pixel ? (len + 1) * 4 : len + 2;
                    if (dist_fld == 0 || back > fill_cnt) begin
                        st = ST_BAD_DIST;
                    end
                    else begin
                        // one byte at a time so overlapping copies see fresh data
                        for (int i = 0; i < count; i++) begin
                            src = (int'(wr_ptr) >= back) ? int'(wr_ptr) - back
                                                         : int'(wr_ptr) + WINDOW_BYTES - back;
                            emit_decoded(window_mem[src]);
                        end
                    end
                end
            end
            else begin
                if (ph == 1)
                    held_word = {8'h00, b};
                else
                    held_word = {b, held_word[7:0]};
                tok_phase = ph;
            end
        end

        if (is_last) begin
            if (tok_phase != 0)
                st = ST_TRUNC;
            restart_stream();
        end

        if (st != ST_OK || (is_last && step_results.size() == 0))
            append_result(8'h00, 1'b0, st);
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].run_last   = 1'b1;
            step_results[step_results.size() - 1].stream_end = is_last;
        end
        foreach (step_results[i])
            pending_results.push_back(step_results[i]);
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    function automatic void check_result();
        decoded_t exp_r;
        if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: expected none, actual byte %0h status %0d",
                     $time, out_ch.out_byte, out_ch.status);
            return;
        end
        exp_r = pending_results.pop_front();
        check_field("out_byte", exp_r.data, out_ch.out_byte);
        check_field("byte_valid", 8'(exp_r.byte_valid), 8'(out_ch.byte_valid));
        check_field("run_last", 8'(exp_r.run_last), 8'(out_ch.run_last));
        check_field("stream_end", 8'(exp_r.stream_end), 8'(out_ch.stream_end));
        check_field("status", 8'(exp_r.status), 8'(out_ch.status));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            restart_stream();
            mode_pixel = 1'b0;
            pending_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (out_ch.valid && out_ch.ready)
                check_result();
            if (cfg_wen)
                mode_pixel = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.in_byte, in_ch.last_byte);
            pending = pending_results.size();
        end
    end

endmodule

// ===== dv/tb_lzss_byte_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// LZSS byte/pixel decoder testbench
// Drives compressed streams in byte and pixel mode: a directed set of edge
// cases, then random well-formed streams with literals, overlapping copies,
// bad distances, truncated tails and noise, under random stalls on both
// channels. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_lzss_byte_pixel_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import lzbp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    typedef enum int {
        TAIL_BOUNDARY,
        TAIL_AFTER_FLAG,
        TAIL_CUT
    } tail_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic        cfg_wdata;
    int unsigned fail_count;
    int unsigned pending;
    int          items_sent;
    bit          quiet;
    bit          pixel_sel;

    lzbp_in_if  in_ch();
    lzbp_out_if out_ch();

    lzss_byte_pixel_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    lzbp_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[lzss_byte_pixel_decoder] ERROR");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= quiet || ($urandom_range(0, 99) >= 14);
        end
    end

    // ready only moves at the rising edge, so its value in the low phase
    // tells whether the coming edge takes the transaction
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (!quiet && $urandom_range(0, 99) < 14) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.last_byte <= is_last;
        while (!in_ch.ready)
            @(negedge clk);
        items_sent++;
        quiet = (items_sent >= 80 && items_sent < 120);
        @(negedge clk);
    endtask

    task automatic play_bytes(input byte_q_t seq);
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    // drop valid, let every expected result drain, then give the decoder
    // time to finish a byte that produces nothing
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_mode(input bit m);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        pixel_sel = m;
    endtask

    // builds one stream whose copies mostly point inside the bytes decoded so far
    task automatic play_stream(input int n_tok, input tail_kind_t tail);
        byte_q_t seq;
        int      flag_idx;
        int      produced;
        int      unit_sz;
        int      max_dist;
        int      dist_fld;
        int      len;
        bit      lit;
        bit      cut;
        produced = 0;
        flag_idx = 0;
        unit_sz  = pixel_sel ? 4 : 1;
        for (int k = 0; k < n_tok; k++) begin
            if (k % 8 == 0) begin
                flag_idx = seq.size();
                seq.push_back(8'($urandom()));
            end
            cut = (tail == TAIL_CUT) && (k == n_tok - 1);
            lit = !cut && ((produced == 0) ? ($urandom_range(0, 9) != 0)
                                           : ($urandom_range(0, 1) == 1));
            seq[flag_idx][k % 8] = lit;
            if (lit) begin
                repeat (pixel_sel ? 3 : 1) seq.push_back(8'($urandom()));
                produced += unit_sz;
            end
            else begin
                len      = $urandom_range(0, 15);
                max_dist = produced / unit_sz;
                if (max_dist > 4095)
                    max_dist = 4095;
                if (max_dist == 0 || $urandom_range(0, 99) < 8) begin
                    dist_fld = (max_dist == 4095 || $urandom_range(0, 1) == 0)
                               ? 0 : $urandom_range(max_dist + 1, 4095);
                end
                else begin
                    dist_fld = $urandom_range(1, max_dist);
                    produced += pixel_sel ? (len + 1) * 4 : len + 2;
                end
                seq.push_back({dist_fld[3:0], len[3:0]});
                if (!cut)
                    seq.push_back(dist_fld[11:4]);
            end
        end
        if (tail == TAIL_AFTER_FLAG)
            seq.push_back(8'($urandom()));
        play_bytes(seq);
    endtask

    initial
    begin
        byte_q_t seq;
        int      pick;
        rst_n           = 1'b0;
        cfg_wen         = 1'b0;
        cfg_wdata       = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        in_ch.last_byte = 1'b0;
        items_sent      = 0;
        quiet           = 1'b0;
        pixel_sel       = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // byte mode: 0x00/0xFF literals, overlapping max-length copy,
        // zero distance, distance past history, valid copy, cut-off copy
        set_mode(1'b0);
        seq = '{8'h83, 8'h00, 8'hFF, 8'h1F, 8'h00, 8'h05, 8'h00,
                8'hF0, 8'hFF, 8'h32, 8'h01, 8'h00};
        play_bytes(seq);
        // stream that ends on its flag byte
        seq = '{8'h5A};
        play_bytes(seq);

        // pixel mode: three-byte literal, then a 64-byte overlapping copy
        set_mode(1'b1);
        seq = '{8'h01, 8'hAB, 8'hCD, 8'hEF, 8'h1F, 8'h00};
        play_bytes(seq);

        // switch to byte mode with two literal bytes already held
        send_byte(8'h01, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        set_mode(1'b0);
        send_byte(8'h33, 1'b1);

        while (items_sent < 160) begin
            if ($urandom_range(0, 3) == 0)
                set_mode(1'($urandom_range(0, 1)));
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                seq.delete();
                repeat ($urandom_range(2, 10)) seq.push_back(8'($urandom()));
                play_bytes(seq);
            end
            else if (pick < 25) begin
                play_stream(8 * $urandom_range(1, 2), TAIL_AFTER_FLAG);
            end
            else if (pick < 40) begin
                play_stream($urandom_range(1, 10), TAIL_CUT);
            end
            else begin
                play_stream($urandom_range(1, 12), TAIL_BOUNDARY);
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[lzss_byte_pixel_decoder] OK");
        else
            $display("[lzss_byte_pixel_decoder] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lzbp_pkg.sv
src/lzbp_if.sv
src/lzbp_ctrl.sv
src/lzbp_datapath.sv
src/lzss_byte_pixel_decoder.sv
dv/lzbp_checker.sv
dv/tb_lzss_byte_pixel_decoder.sv
